// ===== hdl/vpw_pkg.sv =====
// Package: shared types and constants for the VPW frame transmitter.
`timescale 1ns / 1ps

package vpw_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_START = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    REG_SOF   = 2'd0,
    REG_SHORT = 2'd1,
    REG_LONG  = 2'd2
  } cfg_reg_t;

  localparam int unsigned TICK_W = 16;
  localparam int unsigned FILL_W = 5;
  localparam logic [2:0]  BIT_MSB = 3'd7;

  localparam logic [TICK_W-1:0] SOF_RST   = 16'd200;
  localparam logic [TICK_W-1:0] SHORT_RST = 16'd64;
  localparam logic [TICK_W-1:0] LONG_RST  = 16'd128;

  typedef struct packed {
    func_t      func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic              line_level;
    logic              busy_res;
    logic              rejected;
    logic [FILL_W-1:0] fill_level;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] sof_ticks;
    logic [TICK_W-1:0] short_ticks;
    logic [TICK_W-1:0] long_ticks;
  } cfg_t;

endpackage

// ===== hdl/vpw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module vpw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/vpw_ctrl.sv =====
// Frame buffer, symbol sequencer and tick timer of the VPW transmitter.
`timescale 1ns / 1ps

module vpw_ctrl #(
  parameter int BUF_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  vpw_pkg::in_item_t item,
  input  vpw_pkg::cfg_t     cfg,
  output vpw_pkg::out_item_t res
);
  import vpw_pkg::*;

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CW = $clog2(BUF_DEPTH + 1);

  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     pos_inc;
  logic [2:0]        bit_r, bit_nxt;
  logic              sending_r, sending_nxt;
  logic              in_sof_r, in_sof_nxt;
  logic              act_r, act_nxt;
  logic              line_r, line_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;
  logic [7:0]        byte_r, byte_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [7:0]        ram_rdata;
  logic              rej;
  logic              load;
  logic              fin;
  logic              sym_bit;

  assign pos_inc = pos_r + CW'(1);

  // Read port always points at the next byte to send, so its data is
  // ready by the time the current byte (or the SOF pulse) runs out.
  assign ram_raddr = (sending_r && !in_sof_r) ? pos_inc[AW-1:0] : '0;

  vpw_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (item.data_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    bit_nxt     = bit_r;
    sending_nxt = sending_r;
    in_sof_nxt  = in_sof_r;
    act_nxt     = act_r;
    line_nxt    = line_r;
    ticks_nxt   = ticks_r;
    byte_nxt    = byte_r;
    ram_we      = 1'b0;
    rej         = 1'b0;
    load        = 1'b0;
    fin         = 1'b0;
    sym_bit     = 1'b0;

    if (step_en) begin
      unique case (item.func)
        FUNC_TICK: begin
          if (sending_r) begin
            if (ticks_r <= TICK_W'(1)) begin
              if (in_sof_r) begin
                in_sof_nxt = 1'b0;
                if (count_r == '0) begin
                  fin = 1'b1;
                end else begin
                  pos_nxt  = '0;
                  bit_nxt  = BIT_MSB;
                  act_nxt  = 1'b0;
                  byte_nxt = ram_rdata;
                  load     = 1'b1;
                end
              end else begin
                act_nxt = !act_r;
                if (bit_r == 3'd0) begin
                  if (pos_inc >= count_r) begin
                    fin = 1'b1;
                  end else begin
                    pos_nxt  = pos_inc;
                    bit_nxt  = BIT_MSB;
                    byte_nxt = ram_rdata;
                    load     = 1'b1;
                  end
                end else begin
                  bit_nxt = bit_r - 3'd1;
                  load    = 1'b1;
                end
              end
            end else begin
              ticks_nxt = ticks_r - TICK_W'(1);
            end
          end
        end
        FUNC_WRITE: begin
          if (sending_r || count_r >= CW'(BUF_DEPTH)) begin
            rej = 1'b1;
          end else begin
            ram_we    = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        FUNC_START: begin
          if (sending_r) begin
            rej = 1'b1;
          end else begin
            sending_nxt = 1'b1;
            in_sof_nxt  = 1'b1;
            line_nxt    = 1'b1;
            pos_nxt     = '0;
            bit_nxt     = 3'd0;
            act_nxt     = 1'b0;
            ticks_nxt   = cfg.sof_ticks;
          end
        end
        default: ;
      endcase
    end

    // short when the bit matches the phase (passive 0, active 1)
    if (load) begin
      sym_bit   = byte_nxt[bit_nxt];
      line_nxt  = act_nxt;
      ticks_nxt = (sym_bit == act_nxt) ? cfg.short_ticks : cfg.long_ticks;
    end

    if (fin) begin
      sending_nxt = 1'b0;
      in_sof_nxt  = 1'b0;
      line_nxt    = 1'b0;
      count_nxt   = '0;
      pos_nxt     = '0;
      bit_nxt     = 3'd0;
      act_nxt     = 1'b0;
      ticks_nxt   = '0;
    end
  end

  assign res.line_level = line_nxt;
  assign res.busy_res   = sending_nxt;
  assign res.rejected   = rej;
  assign res.fill_level = FILL_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      pos_r     <= '0;
      bit_r     <= 3'd0;
      sending_r <= 1'b0;
      in_sof_r  <= 1'b0;
      act_r     <= 1'b0;
      line_r    <= 1'b0;
      ticks_r   <= '0;
    end else begin
      count_r   <= count_nxt;
      pos_r     <= pos_nxt;
      bit_r     <= bit_nxt;
      sending_r <= sending_nxt;
      in_sof_r  <= in_sof_nxt;
      act_r     <= act_nxt;
      line_r    <= line_nxt;
      ticks_r   <= ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

`ifndef SYNTH
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !sending_r |-> (!line_r && pos_r == '0 && !in_sof_r))
    else $error("idle with line high or stale position");

  a_sof_line: assert property (@(posedge clk) disable iff (!rst_n)
    in_sof_r |-> (sending_r && line_r))
    else $error("SOF phase without active line");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sending_r && !in_sof_r) |-> (pos_r < count_r))
    else $error("byte position past fill count");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (!sending_r && count_r < CW'(BUF_DEPTH)))
    else $error("buffer written while sending or full");

  a_line_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (sending_r && !in_sof_r) |-> (line_r == act_r))
    else $error("line level disagrees with symbol phase");
`endif

endmodule

// ===== hdl/vpw_frame_transmitter_top.sv =====
// Top level: config registers, command channel and result register.
`timescale 1ns / 1ps

// VPW frame transmitter.
// Command channel: in_data (func, data_byte) is taken on any clock edge
// with start high; busy is never raised, so one transaction per cycle.
// func write appends a byte to the frame buffer, start sends the SOF pulse
// and then every buffered byte MSB first, tick advances the symbol timer.
// Result channel: every command gives exactly one result on out_data in the
// next cycle, marked by a one-cycle out_valid strobe; the receiver has no
// stall, so results are simply presented and dropped after that cycle.
// Throughput 1 transaction per cycle, set by the single step register stage
// around the sequencer; the frame buffer RAM is read ahead of use so byte
// changes never stall the symbol stream.
// Config: cfg_we writes cfg_wdata to register cfg_idx (0 SOF length,
// 1 short symbol, 2 long symbol, in ticks) at the clock edge; write only
// while no frame is in flight. Other indexes are ignored.
// Reset (synchronous, rst_n low): line low, not sending, buffer empty,
// lengths back to 200 / 64 / 128 ticks.
module vpw_frame_transmitter_top #(
  parameter int BUF_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  vpw_pkg::in_item_t  in_data,
  output logic               out_valid,
  output vpw_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [15:0]        cfg_wdata
);
  import vpw_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  out_item_t res;
  out_item_t out_r;
  logic      out_valid_r;
  logic      step_en;

  assign busy    = 1'b0;
  assign step_en = start && !busy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_SOF:   cfg_nxt.sof_ticks   = cfg_wdata;
        REG_SHORT: cfg_nxt.short_ticks = cfg_wdata;
        REG_LONG:  cfg_nxt.long_ticks  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sof_ticks   <= SOF_RST;
      cfg_r.short_ticks <= SHORT_RST;
      cfg_r.long_ticks  <= LONG_RST;
      out_valid_r       <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= step_en;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= res;
  end

  vpw_ctrl #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_data),
    .cfg     (cfg_r),
    .res     (res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
